FILE: src/lsm_pkg.sv
// Package for the line substring matcher: default sizes, field widths,
// the newline code and the configuration register indexes.
// No dependencies.
package lsm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int BYTE_W        = 8;
    localparam int PLEN_W        = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int PAT_REGS      = 4;
    localparam int PAT_REG_BYTES = PAT_REGS * CFG_DATA_W / BYTE_W;
    localparam int LEN_FIELD_W   = 16;
    localparam int POS_FIELD_W   = 16;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH,
        REG_PATTERN_BYTES_0,
        REG_PATTERN_BYTES_1,
        REG_PATTERN_BYTES_2,
        REG_PATTERN_BYTES_3,
        REG_INVERT_MATCH
    } cfg_reg_t;

endpackage

FILE: src/line_substring_matcher.sv
// Line substring matcher top level: splits a byte stream into lines and
// reports per line whether a fixed pattern matches. Uses lsm_pkg.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------------------
//   in       | in        | in_valid / in_stall    | byte_value, last_in_file
//   out      | out       | out_valid / out_stall  | line_selected, line_length,
//            |           |                        | match_position
//   cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle while no closing byte is held. The pattern window is
// compared while a byte sits in the input register; a line result lands in
// the output register, so out_valid rises once the closing byte has passed
// the input and output registers. Reset restores pattern length 1, a zero
// pattern, no inversion and an empty line. While a result waits under
// out_stall, only a closing byte waits in the input register; others flow.
module line_substring_matcher
#(
    parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = lsm_pkg::COUNT_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lsm_pkg::BYTE_W-1:0]       byte_value,
    input  logic                             last_in_file,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             line_selected,
    output logic [lsm_pkg::LEN_FIELD_W-1:0]  line_length,
    output logic [lsm_pkg::POS_FIELD_W-1:0]  match_position,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lsm_pkg::*;

    localparam int WINDOW = MAX_PATTERN - 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [PLEN_W-1:0]     plen_reg;
    logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
    logic                  inv_reg;

    // input register
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  last_reg;

    // line state
    logic [BYTE_W-1:0]     recent_reg [WINDOW];
    logic [COUNT_BITS-1:0] count_reg;
    logic                  found_reg;
    logic [COUNT_BITS-1:0] start_reg;

    // output register
    logic                   out_valid_reg;
    logic                   sel_reg;
    logic [LEN_FIELD_W-1:0] len_reg;
    logic [POS_FIELD_W-1:0] pos_reg;

    logic                  is_newline;
    logic                  closes;
    logic                  out_free;
    logic                  proc_ok;
    logic                  proc_fire;
    logic                  in_fire;

    logic [LEN_W-1:0]            act_len;
    logic [BYTE_W-1:0]           pbyte [MAX_PATTERN];
    logic [BYTE_W-1:0]           win [MAX_PATTERN];
    logic [MAX_PATTERN*BYTE_W-1:0] rev_pat;
    logic [MAX_PATTERN*BYTE_W-1:0] aligned;
    logic [LEN_W-1:0]            shift_bytes;
    logic [MAX_PATTERN-1:0]      pos_ok;
    logic                        saturated;
    logic [COUNT_BITS-1:0]       count_upd;
    logic                        hit;
    logic                        found_upd;
    logic [COUNT_BITS-1:0]       start_upd;

    logic                        sel_next;
    logic [COUNT_BITS-1:0]       len_next;
    logic [COUNT_BITS-1:0]       pos_next;

    assign cfg_ready = 1'b1;

    assign is_newline = (byte_reg == NEWLINE_BYTE);
    assign closes     = is_newline || last_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign proc_ok    = !closes || out_free;
    assign proc_fire  = in_valid_reg && proc_ok;
    assign in_stall   = in_valid_reg && !proc_ok;
    assign in_fire    = in_valid && !in_stall;

    // active pattern length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (plen_reg == '0)
        begin
            act_len = LEN_W'(1);
        end
        else if (32'(plen_reg) > 32'(MAX_PATTERN))
        begin
            act_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            act_len = LEN_W'(plen_reg);
        end
    end

    // pattern bytes, window, and pattern aligned so that entry j faces win[j]
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < PAT_REG_BYTES)
            begin
                pbyte[i] = pat_reg[i >> 3][(i & 7) * BYTE_W +: BYTE_W];
            end
            else
            begin
                pbyte[i] = '0;
            end
        end
        win[0] = byte_reg;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win[j] = recent_reg[j - 1];
        end
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            rev_pat[j * BYTE_W +: BYTE_W] = pbyte[MAX_PATTERN - 1 - j];
        end
    end

    assign shift_bytes = LEN_W'(MAX_PATTERN) - act_len;
    assign aligned     = rev_pat >> {shift_bytes, 3'b000};

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pos_ok[j] = (32'(j) >= 32'(act_len))
                     || (win[j] == aligned[j * BYTE_W +: BYTE_W]);
        end
    end

    assign saturated = (count_reg == COUNT_MAX);
    assign count_upd = saturated ? COUNT_MAX : count_reg + 1'b1;
    assign hit       = (saturated || (count_upd >= COUNT_BITS'(act_len))) && (&pos_ok);
    assign found_upd = found_reg || hit;
    assign start_upd = (hit && !found_reg)
                     ? (saturated ? COUNT_MAX
                                  : count_upd - COUNT_BITS'(act_len) + 1'b1)
                     : start_reg;

    always_comb
    begin
        if (is_newline)
        begin
            sel_next = found_reg ^ inv_reg;
            len_next = count_reg;
            pos_next = start_reg;
        end
        else
        begin
            sel_next = found_upd ^ inv_reg;
            len_next = count_upd;
            pos_next = start_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= PLEN_W'(1);
            for (int r = 0; r < PAT_REGS; r++)
            begin
                pat_reg[r] <= '0;
            end
            inv_reg       <= 1'b0;
            in_valid_reg  <= 1'b0;
            for (int k = 0; k < WINDOW; k++)
            begin
                recent_reg[k] <= '0;
            end
            count_reg     <= '0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH:  plen_reg   <= cfg_data[PLEN_W-1:0];
                    REG_PATTERN_BYTES_0: pat_reg[0] <= cfg_data;
                    REG_PATTERN_BYTES_1: pat_reg[1] <= cfg_data;
                    REG_PATTERN_BYTES_2: pat_reg[2] <= cfg_data;
                    REG_PATTERN_BYTES_3: pat_reg[3] <= cfg_data;
                    REG_INVERT_MATCH:    inv_reg    <= cfg_data[0];
                    default:             ;
                endcase
            end

            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                if (closes)
                begin
                    for (int k = 0; k < WINDOW; k++)
                    begin
                        recent_reg[k] <= '0;
                    end
                    count_reg <= '0;
                    found_reg <= 1'b0;
                    start_reg <= '0;
                end
                else
                begin
                    recent_reg[0] <= byte_reg;
                    for (int k = 1; k < WINDOW; k++)
                    begin
                        recent_reg[k] <= recent_reg[k - 1];
                    end
                    count_reg <= count_upd;
                    found_reg <= found_upd;
                    start_reg <= start_upd;
                end
            end

            if (proc_fire && closes)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= byte_value;
            last_reg <= last_in_file;
        end
        if (proc_fire && closes)
        begin
            sel_reg <= sel_next;
            len_reg <= LEN_FIELD_W'(len_next);
            pos_reg <= POS_FIELD_W'(pos_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_selected  = sel_reg;
    assign line_length    = len_reg;
    assign match_position = pos_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && closes) |=> (count_reg == '0) && !found_reg)
        else $error("line state not cleared after line end");

    a_found_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (start_reg != '0))
        else $error("match recorded without a start position");

    a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && closes))
        else $error("result produced without a line end");
`endif

endmodule
